[rtl/core/lu8d_pkg.sv]
// Shared types and decode helpers for the lenient UTF-8 decoder.
// Depends on nothing; the top level, front end and back end import it.
package lu8d_pkg;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    // One accepted input transaction.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [20:0] code_point;
        logic        run_last;
        logic        text_end;
    } t_out_item;

    // Work handed from the front to the back: up to four bytes to parse
    // from the first one, the number of valid bytes (1 to 4), and whether
    // this closes the text.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            last;
    } t_job;

    // Sequence length from a lead byte: 1 to 4, or 0 for a bad lead.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    // Code point of a complete sequence. Continuation bytes contribute only
    // their low six bits.
    function automatic logic [20:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [2:0] len);
        logic [20:0] cp;
        case (len)
            3'd2: cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: cp = {13'd0, b0};
        endcase
        return cp;
    endfunction

endpackage

[rtl/core/lenient_utf8_decoder_unit.sv]
// Top level of the lenient UTF-8 decoder: front end, job queue, back end
// and result queue. Depends on lu8d_pkg, lu8d_front, lu8d_back, lu8d_fifo.
//
// Bytes of a text come in as input transactions, taken at a rising edge
// where push is high and full is low. Code points go out as result
// transactions: while empty is low the oldest result sits on o_out_item,
// and it leaves at an edge where pop is high.
// A byte that yields a code point is written into the job queue at the
// edge that accepts it, and the back end moves the result into the result
// queue at the next edge when no older job is ahead and the queue has room.
// Throughput: one byte per cycle while full is low. A byte gives at most
// one result, except the last byte of a text, which parses the held bytes
// again and gives one to three results, one per cycle in the back end
// while the result queue has room. Bytes that only extend an open
// sequence give no result and push no job to the back end.
// Reset (synchronous, active low) empties both queues and drops any open
// sequence; held byte registers keep stale data that is never read.
// When the receiver stalls, the result queue fills, the back end holds,
// then the job queue fills and full rises; nothing is lost.
module lenient_utf8_decoder_unit
    import lu8d_pkg::*;
#(
    parameter int JOB_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    logic      accept;
    logic      job_push;
    t_job      job_in;
    t_job      job_head;
    logic      job_empty;
    logic      job_pop;
    logic      res_full;
    logic      res_push;
    t_out_item res_in;

    // The job queue's full flag is the input side's back-pressure.
    assign accept = push && !full;

    lu8d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    lu8d_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_head),
        .o_empty (job_empty)
    );

    lu8d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_head),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    lu8d_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );

endmodule

[rtl/core/lu8d_fifo.sv]
// Small first-word-fall-through queue of registers.
// Depends on nothing; used for the job queue and the result queue.
module lu8d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/core/lu8d_front.sv]
// Front end: holds the bytes of an open sequence and turns each accepted
// byte into either a stored byte or a parse job. Depends on lu8d_pkg.
module lu8d_front
    import lu8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_job_push,
    output t_job     o_job
);

    logic [7:0] r_pend [3];
    logic [1:0] r_pcount, n_pcount;
    logic [2:0] r_elen, n_elen;
    logic       store;
    logic [1:0] store_idx;
    logic       open_seq;
    logic       complete;
    logic [2:0] len;

    assign open_seq = (r_pcount != 2'd0) && (r_elen >= 3'd2) && (r_elen <= 3'd4);
    assign complete = ({1'b0, r_pcount} + 3'd1) >= r_elen;
    assign len      = lead_length(i_item.text_byte);

    always_comb begin
        o_job_push = 1'b0;
        store      = 1'b0;
        store_idx  = r_pcount;
        n_pcount   = r_pcount;
        n_elen     = r_elen;
        // Job bytes: held bytes first, then the new byte.
        for (int j = 0; j < 4; j++) begin
            if (j < 3 && 2'(j) < r_pcount) begin
                o_job.bytes[j] = r_pend[j];
            end else begin
                o_job.bytes[j] = i_item.text_byte;
            end
        end
        o_job.count = {1'b0, r_pcount} + 3'd1;
        o_job.last  = i_item.text_last;

        if (i_item.text_last) begin
            // End of text: everything held plus this byte is parsed again.
            o_job_push = i_accept;
            n_pcount   = 2'd0;
            n_elen     = 3'd0;
        end else if (!open_seq) begin
            n_pcount = 2'd0;
            n_elen   = 3'd0;
            o_job.bytes[0] = i_item.text_byte;
            o_job.count    = 3'd1;
            if (len == 3'd1 || len == 3'd0) begin
                o_job_push = i_accept;
            end else begin
                store     = 1'b1;
                store_idx = 2'd0;
                n_pcount  = 2'd1;
                n_elen    = len;
            end
        end else if (complete) begin
            o_job_push = i_accept;
            n_pcount   = 2'd0;
            n_elen     = 3'd0;
        end else begin
            store    = 1'b1;
            n_pcount = r_pcount + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= 2'd0;
            r_elen   <= 3'd0;
        end else if (i_accept) begin
            r_pcount <= n_pcount;
            r_elen   <= n_elen;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            if (i_accept && store && store_idx == 2'(j)) begin
                r_pend[j] <= i_item.text_byte;
            end
        end
    end

endmodule

[rtl/core/lu8d_back.sv]
// Back end: while the result queue has room, walks the head job one code
// point per cycle and pushes the results into it. Depends on lu8d_pkg.
module lu8d_back
    import lu8d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_job_empty,
    output logic      o_job_pop,
    input  logic      i_res_full,
    output logic      o_res_push,
    output t_out_item o_res
);

    logic [1:0] r_pos, n_pos;
    logic [7:0] lead;
    logic [2:0] len;
    logic [2:0] remain;
    logic [2:0] adv;
    logic [2:0] next_pos;
    logic       done;
    logic       step;

    assign step   = !i_job_empty && !i_res_full;
    assign lead   = i_job.bytes[r_pos];
    assign len    = lead_length(lead);
    assign remain = i_job.count - {1'b0, r_pos};

    always_comb begin
        if (len == 3'd1) begin
            o_res.code_point = {13'd0, lead};
            adv              = 3'd1;
        end else if (len >= 3'd2 && len <= remain) begin
            o_res.code_point = assemble(lead, i_job.bytes[r_pos + 2'd1],
                                        i_job.bytes[r_pos + 2'd2],
                                        i_job.bytes[r_pos + 2'd3], len);
            adv              = len;
        end else begin
            o_res.code_point = REPLACEMENT_CP;
            adv              = 3'd1;
        end
        next_pos       = {1'b0, r_pos} + adv;
        done           = next_pos >= i_job.count;
        o_res.run_last = done;
        o_res.text_end = done && i_job.last;
        o_res_push     = step;
        o_job_pop      = step && done;
        n_pos          = r_pos;
        if (step) begin
            n_pos = done ? 2'd0 : next_pos[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the lenient UTF-8 decoder unit.
// Depends on lu8d_pkg and lenient_utf8_decoder_unit; nothing else.
module tb_top;
    import lu8d_pkg::*;

    // The watchdog fires after this many cycles in which no transaction
    // moves on either side. Pacing gaps and a drain hold last far less.
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_BYTES   = 125;
    localparam int TAIL_CYCLES   = 12;
    localparam int REPORT_LIMIT  = 10;

    // Pacing per phase, in percent of cycles spent idle.
    localparam int SEND_IDLE [3] = '{36, 56, 0};
    localparam int RECV_IDLE [3] = '{56, 36, 0};

    // One byte waiting to be sent. When drain_first is set, the sender
    // holds this byte back until every expected code point has arrived.
    typedef struct {
        t_in_item item;
        bit       drain_first;
        int       phase;
    } t_byte_entry;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_in_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_out_item;

    t_byte_entry byte_queue [$];
    t_out_item   expected_cps [$];

    // Shadow of the decoder state: bytes held for an open sequence, their
    // number, and the length that the opening lead announced.
    logic [7:0] held_byte [3];
    int         held_cnt = 0;
    int         seq_len = 0;

    int cur_phase = 0;
    int mismatch_cnt = 0;
    int bytes_sent = 0;
    int cps_checked = 0;
    int texts_built = 0;
    int quiet_cycles = 0;

    lenient_utf8_decoder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Length announced by a lead byte; zero when the byte opens nothing.
    function automatic int seq_length_of(input logic [7:0] b);
        int len;
        if (b[7] == 1'b0) begin
            len = 1;
        end else if (b[7:5] == 3'b110) begin
            len = 2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3;
        end else if (b[7:3] == 5'b11110) begin
            len = 4;
        end else begin
            len = 0;
        end
        return len;
    endfunction

    // Builds the code point of a complete sequence of len bytes starting at
    // position first. Continuation bytes give only their low six bits.
    function automatic logic [20:0] join_seq(input logic [3:0][7:0] bs, input int first,
                                             input int len);
        logic [31:0] acc;
        int j;
        if (len == 2) begin
            acc = {27'd0, bs[first][4:0]};
        end else if (len == 3) begin
            acc = {28'd0, bs[first][3:0]};
        end else if (len == 4) begin
            acc = {29'd0, bs[first][2:0]};
        end else begin
            acc = {24'd0, bs[first]};
        end
        for (j = 1; j < len; j++) begin
            acc = (acc << 6) | {26'd0, bs[first + j][5:0]};
        end
        return acc[20:0];
    endfunction

    // Updates the shadow state for one accepted byte and queues the code
    // points that it should produce.
    function automatic void decode_byte(input t_in_item it);
        logic [3:0][7:0] bs;
        t_out_item res [4];
        int n_res;
        int n;
        int pos;
        int len;
        int k;
        bs = '0;
        n_res = 0;
        if (it.text_last) begin
            // End of text: whatever is held plus this byte is parsed again
            // from the start, each position taken as a lead.
            n = 0;
            for (k = 0; k < held_cnt; k++) begin
                bs[n] = held_byte[k];
                n++;
            end
            bs[n] = it.text_byte;
            n++;
            pos = 0;
            while (pos < n) begin
                len = seq_length_of(bs[pos]);
                res[n_res] = '0;
                if (len == 1) begin
                    res[n_res].code_point = {13'd0, bs[pos]};
                    pos += 1;
                end else if (len >= 2 && pos + len <= n) begin
                    res[n_res].code_point = join_seq(bs, pos, len);
                    pos += len;
                end else begin
                    res[n_res].code_point = REPLACEMENT_CP;
                    pos += 1;
                end
                n_res++;
            end
            res[n_res - 1].text_end = 1'b1;
            held_cnt = 0;
            seq_len = 0;
        end else if (held_cnt == 0 || seq_len < 2) begin
            len = seq_length_of(it.text_byte);
            held_cnt = 0;
            seq_len = 0;
            res[0] = '0;
            if (len == 1) begin
                res[0].code_point = {13'd0, it.text_byte};
                n_res = 1;
            end else if (len == 0) begin
                res[0].code_point = REPLACEMENT_CP;
                n_res = 1;
            end else begin
                held_byte[0] = it.text_byte;
                held_cnt = 1;
                seq_len = len;
            end
        end else if (held_cnt + 1 >= seq_len) begin
            for (k = 0; k < held_cnt; k++) begin
                bs[k] = held_byte[k];
            end
            bs[held_cnt] = it.text_byte;
            res[0] = '0;
            res[0].code_point = join_seq(bs, 0, held_cnt + 1);
            n_res = 1;
            held_cnt = 0;
            seq_len = 0;
        end else begin
            held_byte[held_cnt] = it.text_byte;
            held_cnt++;
        end
        if (n_res > 0) begin
            res[n_res - 1].run_last = 1'b1;
        end
        for (k = 0; k < n_res; k++) begin
            expected_cps.insert(expected_cps.size(), res[k]);
        end
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic last, input int ph,
                                     input bit drain_first);
        t_byte_entry e;
        e.item.text_byte = b;
        e.item.text_last = last;
        e.drain_first = drain_first;
        e.phase = ph;
        byte_queue.insert(byte_queue.size(), e);
        if (last) begin
            texts_built++;
        end
    endfunction

    // Mostly a proper continuation byte, now and then any byte at all,
    // since the decoder never checks them.
    function automatic logic [7:0] cont_byte();
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0) begin
            b = 8'($urandom_range(0, 255));
        end else begin
            b = {2'b10, 6'($urandom_range(0, 63))};
        end
        return b;
    endfunction

    // Builds one random text, mostly well-formed sequences with random
    // payload bits, with bad leads, stray bytes and a cut-off final
    // sequence mixed in.
    task automatic add_text(input int ph, input bit drain_first, inout int total);
        logic [7:0] txt [$];
        logic [7:0] lead;
        int n_chars;
        int c;
        int len;
        int j;
        n_chars = $urandom_range(1, 10);
        len = 1;
        for (c = 0; c < n_chars; c++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    len = 1;
                    lead = {1'b0, 7'($urandom_range(0, 127))};
                end
                4: begin
                    len = 2;
                    lead = {3'b110, 5'($urandom_range(0, 31))};
                end
                5: begin
                    len = 3;
                    lead = {4'b1110, 4'($urandom_range(0, 15))};
                end
                6, 9: begin
                    len = 4;
                    lead = {5'b11110, 3'($urandom_range(0, 7))};
                end
                7: begin
                    len = 1;
                    if ($urandom_range(0, 1) == 0) begin
                        lead = {2'b10, 6'($urandom_range(0, 63))};
                    end else begin
                        lead = {5'b11111, 3'($urandom_range(0, 7))};
                    end
                end
                default: begin
                    len = 1;
                    lead = 8'($urandom_range(0, 255));
                end
            endcase
            txt.insert(txt.size(), lead);
            for (j = 1; j < len; j++) begin
                txt.insert(txt.size(), cont_byte());
            end
        end
        // Cut the final sequence short now and then so that the end of
        // text has held bytes to parse again.
        if (len >= 2 && $urandom_range(0, 2) == 0) begin
            for (j = $urandom_range(1, len - 1); j > 0; j--) begin
                void'(txt.pop_back());
            end
        end
        for (j = 0; j < txt.size(); j++) begin
            add_byte(txt[j], j == txt.size() - 1, ph, drain_first && j == 0);
        end
        total += txt.size();
    endtask

    // Sender. The byte at the head of the queue is offered until it is
    // taken; the prediction is made at the edge where it is accepted.
    always @(posedge i_clk) begin : text_sender
        t_byte_entry head;
        t_in_item nxt_item;
        logic nxt_push;
        if (i_rst_n) begin
            if (push && !full) begin
                decode_byte(i_in_item);
                bytes_sent++;
                void'(byte_queue.pop_front());
            end
            nxt_push = 1'b0;
            nxt_item = {8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))};
            if (byte_queue.size() != 0) begin
                head = byte_queue[0];
                cur_phase <= head.phase;
                // A byte marked for draining waits until the decoder has
                // handed back every code point that is still owed.
                if (!(head.drain_first && expected_cps.size() != 0)) begin
                    nxt_push = $urandom_range(0, 99) >= SEND_IDLE[head.phase];
                end
                if (nxt_push) begin
                    nxt_item = head.item;
                end
            end
            push <= nxt_push;
            i_in_item <= nxt_item;
        end
    end

    // Receiver. Every accepted result transaction is checked against the
    // oldest expected code point.
    always @(posedge i_clk) begin : cp_receiver
        t_out_item want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_cps.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT) begin
                        $display("[%0t] unexpected result: cp=%06h run_last=%b text_end=%b",
                                 $realtime, o_out_item.code_point, o_out_item.run_last,
                                 o_out_item.text_end);
                    end
                end else begin
                    want = expected_cps.pop_front();
                    if (o_out_item.code_point !== want.code_point
                        || o_out_item.run_last !== want.run_last
                        || o_out_item.text_end !== want.text_end) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT) begin
                            $display("[%0t] result %0d wrong: expected cp=%06h run_last=%b",
                                     $realtime, cps_checked, want.code_point, want.run_last,
                                     " text_end=%b, got cp=%06h run_last=%b text_end=%b",
                                     want.text_end, o_out_item.code_point,
                                     o_out_item.run_last, o_out_item.text_end);
                        end
                    end
                end
                cps_checked++;
            end
            pop <= $urandom_range(0, 99) >= RECV_IDLE[cur_phase];
        end
    end

    // Watchdog: a hang on either side shows up as a long run of cycles in
    // which no transaction completes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[%0t] watchdog: no transaction for %0d cycles, %0d bytes left",
                         $realtime, quiet_cycles, byte_queue.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int ph;
        int phase_total;
        // Directed texts: field extremes, bad leads, every sequence length,
        // the largest code point, and the end-of-text cases.
        add_byte(8'h00, 1'b0, 0, 1'b0);
        add_byte(8'h7F, 1'b0, 0, 1'b0);
        add_byte(8'h80, 1'b0, 0, 1'b0);          // stray continuation as lead
        add_byte(8'hFF, 1'b0, 0, 1'b0);
        add_byte(8'hF8, 1'b0, 0, 1'b0);
        add_byte(8'hC2, 1'b0, 0, 1'b0);
        add_byte(8'hA9, 1'b0, 0, 1'b0);
        add_byte(8'hE2, 1'b0, 0, 1'b0);
        add_byte(8'h82, 1'b0, 0, 1'b0);
        add_byte(8'hAC, 1'b0, 0, 1'b0);
        add_byte(8'hF7, 1'b0, 0, 1'b0);          // all payload bits set
        add_byte(8'hBF, 1'b0, 0, 1'b0);
        add_byte(8'hBF, 1'b0, 0, 1'b0);
        add_byte(8'hBF, 1'b0, 0, 1'b0);
        add_byte(8'hC3, 1'b1, 0, 1'b0);          // multi-byte lead ends the text
        add_byte(8'hE2, 1'b0, 0, 1'b0);          // cut-off sequence at the end
        add_byte(8'h82, 1'b1, 0, 1'b0);
        add_byte(8'hF0, 1'b0, 0, 1'b0);          // reparse gives three results
        add_byte(8'h41, 1'b0, 0, 1'b0);
        add_byte(8'hC3, 1'b1, 0, 1'b0);
        add_byte(8'hDF, 1'b0, 0, 1'b0);          // sequence completes on the end
        add_byte(8'hBF, 1'b1, 0, 1'b0);
        add_byte(8'h41, 1'b1, 0, 1'b0);          // one-byte text

        // Random texts in three pacing phases; each phase opens with a
        // drain so that the decoder starts it empty.
        for (ph = 0; ph < 3; ph++) begin
            phase_total = 0;
            add_text(ph, 1'b1, phase_total);
            while (phase_total < PHASE_BYTES) begin
                add_text(ph, 1'b0, phase_total);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (byte_queue.size() != 0 || expected_cps.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d texts and checked %0d code points,",
                 bytes_sent, texts_built, cps_checked);
        $display("under skewed, reversed and free-running handshake pacing.");
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
